@@ src/bffa_pkg.sv @@
// bffa_pkg: types and constants for the bitmap first-fit allocator
// used by bitmap_first_fit_allocator, no dependencies
package bffa_pkg;

  localparam int unsigned MaxBlocks   = 4;
  localparam int unsigned HeaderBytes = 512;
  localparam int unsigned BlockBytes  = 4096;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_INIT = 2'd1,
    ST_BAD_SZ  = 2'd2,
    ST_NO_ROOM = 2'd3
  } status_e;

  typedef enum logic {
    CFG_BLOCK_COUNT  = 1'b0,
    CFG_BASE_ADDRESS = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_SCAN,
    FS_MARK,
    FS_FREE,
    FS_CLEAR,
    FS_DONE
  } fsm_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [14:0] request_size;
    logic [10:0] run_byte;
    logic [2:0]  run_bit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] found_byte;
    logic [2:0]  found_bit;
    logic [14:0] granted_size;
    logic [63:0] granted_address;
  } out_item_t;

endpackage

@@ src/bffa_ram.sv @@
// bffa_ram: generic synchronous ram with one write port and one read port, registered read
// no dependencies
module bffa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ src/bitmap_first_fit_allocator.sv @@
// Bitmap first-fit allocator: keeps a used-bit map (one bit per heap byte) in a
// RAM of HeaderBytes*MaxBlocks bytes (one write and one read port). One
// transaction at a time. Allocate scans the active map byte by byte (read, then
// test), then marks the run with one read-modify-write per byte. Free also does
// one read-modify-write per touched byte; clear writes zero to every map byte.
// After reset a clearing pass runs before the first transaction is accepted;
// configuration writes are taken anytime.
// depends on bffa_pkg and bffa_ram
module bitmap_first_fit_allocator #(
  parameter int unsigned MaxBlocks   = bffa_pkg::MaxBlocks,
  parameter int unsigned HeaderBytes = bffa_pkg::HeaderBytes,
  parameter int unsigned BlockBytes  = bffa_pkg::BlockBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [63:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bffa_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bffa_pkg::out_item_t out_data_o
);
  localparam int unsigned Depth = HeaderBytes * MaxBlocks;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned PW    = AW + 3;
  localparam int unsigned BW    = $clog2(MaxBlocks + 1);
  localparam int unsigned LimW  = $clog2(Depth * 8 + 1);

  logic [2:0]  blocks_q;
  logic [63:0] base_q;
  logic [BW-1:0] act;
  logic [LimW-1:0] limit;  // active map size in bits

  bffa_pkg::fsm_e st_q, st_d;
  bffa_pkg::in_item_t req_q;
  logic [LimW-1:0] p_q, p_d;          // bit cursor (multiple of 8 during scan)
  logic [LimW-1:0] start_q, start_d;
  logic [14:0] cnt_q, cnt_d;          // free bits counted in current run
  logic [15:0] left_q, left_d;        // bits still to write
  logic        rd_ok_q, rd_ok_d;      // ram data valid for p_q byte
  logic [AW:0] clr_q, clr_d;
  logic        out_v_q;
  bffa_pkg::out_item_t out_q, out_d;
  logic        done_set;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  always_comb begin
    act = (32'(blocks_q) > MaxBlocks) ? BW'(MaxBlocks) : BW'(blocks_q);
    limit = LimW'(act) * LimW'(HeaderBytes * 8);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_q <= '0;
      base_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == bffa_pkg::CFG_BLOCK_COUNT) blocks_q <= cfg_wdata_i[2:0];
      else base_q <= cfg_wdata_i;
    end
  end

  bffa_ram #(.Width(8), .Depth(Depth)) u_map (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign in_stall_o = (st_q != bffa_pkg::FS_IDLE) || out_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // per-byte scan step results
  logic        hit;
  logic [14:0] cnt_end;
  logic [3:0]  last_used;     // index+1 of last used bit before the hit, 0 if none
  logic [LimW-1:0] hit_start;
  logic [7:0]  mmask;
  logic [3:0]  nbits;
  logic [2:0]  bofs;
  logic [LimW-1:0] room;

  always_comb begin
    hit = 1'b0;
    last_used = '0;
    cnt_end = cnt_q;
    for (int k = 0; k < 8; k++) begin
      if (rdata[k]) begin
        if (!hit) last_used = 4'(k + 1);
        cnt_end = '0;
      end else begin
        cnt_end = cnt_end + 15'd1;
        if (!hit && cnt_end == req_q.request_size) hit = 1'b1;
      end
    end
    if (rdata == 8'hff) begin
      cnt_end = '0;
      last_used = 4'd8;
    end
    // run starts after the last used bit of this byte, else carries over
    hit_start = (last_used != '0) ? p_q + LimW'(last_used) : start_q;
  end

  // write mask for the byte at p_q during mark/free
  always_comb begin
    bofs = p_q[2:0];
    room = limit - p_q;
    nbits = 4'd8 - 4'(bofs);
    if (left_q < 16'(nbits)) nbits = 4'(left_q);
    if (room < LimW'(nbits)) nbits = 4'(room);
    mmask = 8'((9'h1 << nbits) - 9'h1) << bofs;
  end

  always_comb begin
    st_d = st_q; p_d = p_q; start_d = start_q; cnt_d = cnt_q; left_d = left_q;
    rd_ok_d = 1'b0; clr_d = clr_q; out_d = out_q; done_set = 1'b0;
    we = 1'b0; waddr = p_q[PW-1:3]; wdata = '0; raddr = p_q[PW-1:3];
    case (st_q)
      bffa_pkg::FS_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          out_d = '0;
          p_d = '0; start_d = '0; cnt_d = '0;
          case (in_data_i.opcode)
            bffa_pkg::OP_ALLOC: begin
              if (act == '0) begin
                out_d.status = bffa_pkg::ST_NO_INIT;
                st_d = bffa_pkg::FS_DONE;
              end else if (in_data_i.request_size == '0 ||
                           32'(in_data_i.request_size) > 32'(act) * BlockBytes) begin
                out_d.status = bffa_pkg::ST_BAD_SZ;
                st_d = bffa_pkg::FS_DONE;
              end else st_d = bffa_pkg::FS_SCAN;
            end
            bffa_pkg::OP_FREE: begin
              p_d = LimW'({in_data_i.run_byte, in_data_i.run_bit});
              left_d = 16'(in_data_i.request_size);
              st_d = bffa_pkg::FS_FREE;
            end
            bffa_pkg::OP_CLEAR: begin
              clr_d = '0;
              st_d = bffa_pkg::FS_CLEAR;
            end
            default: st_d = bffa_pkg::FS_DONE;
          endcase
        end
      end
      bffa_pkg::FS_SCAN: begin
        if (p_q >= limit) begin
          out_d.status = bffa_pkg::ST_NO_ROOM;
          st_d = bffa_pkg::FS_DONE;
        end else if (!rd_ok_q) begin
          rd_ok_d = 1'b1;
        end else if (hit) begin
          left_d = 16'(req_q.request_size);
          out_d.found_byte = hit_start[PW-1:3];
          out_d.found_bit = hit_start[2:0];
          out_d.granted_size = req_q.request_size;
          out_d.granted_address = base_q + 64'(hit_start);
          p_d = hit_start;
          st_d = bffa_pkg::FS_MARK;
        end else begin
          cnt_d = cnt_end;
          if (last_used != '0) start_d = p_q + LimW'(last_used);
          p_d = p_q + LimW'(8);
        end
      end
      bffa_pkg::FS_MARK, bffa_pkg::FS_FREE: begin
        if (left_q == '0 || p_q >= limit) begin
          st_d = bffa_pkg::FS_DONE;
        end else if (!rd_ok_q) begin
          rd_ok_d = 1'b1;
        end else begin
          we = 1'b1;
          wdata = (st_q == bffa_pkg::FS_MARK) ? (rdata | mmask) : (rdata & ~mmask);
          left_d = left_q - 16'(nbits);
          p_d = p_q + LimW'(nbits);
        end
      end
      bffa_pkg::FS_CLEAR: begin
        we = 1'b1;
        waddr = clr_q[AW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q == (AW+1)'(Depth - 1)) st_d = bffa_pkg::FS_DONE;
      end
      bffa_pkg::FS_DONE: begin
        done_set = 1'b1;
        st_d = bffa_pkg::FS_IDLE;
      end
      default: st_d = bffa_pkg::FS_IDLE;
    endcase
  end

  // the reset clearing pass must not emit a result
  logic init_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) init_q <= 1'b1;
    else if (st_q == bffa_pkg::FS_DONE) init_q <= 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= bffa_pkg::FS_CLEAR;   // clearing pass after reset
      clr_q <= '0;
      out_v_q <= 1'b0;
      rd_ok_q <= 1'b0;
      p_q <= '0; start_q <= '0; cnt_q <= '0; left_q <= '0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; rd_ok_q <= rd_ok_d;
      p_q <= p_d; start_q <= start_d; cnt_q <= cnt_d; left_q <= left_d;
      if (done_set && !init_q)
        out_v_q <= 1'b1;
      else if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == bffa_pkg::FS_IDLE && in_valid_i && !in_stall_o) req_q <= in_data_i;
    out_q <= out_d;
  end
endmodule
